>>> design/rtnh_pkg.sv
package rtnh_pkg;

  localparam int COORD_W       = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int EDGE_W        = COORD_W + 1;
  localparam int CROSS_W       = 64;
  localparam int ACC_W         = 128;
  localparam int DIST_W        = 31;
  localparam int CFG_IDX_W     = 3;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORG_X = 3'd0,
    CFG_ORG_Y = 3'd1,
    CFG_ORG_Z = 3'd2,
    CFG_DIR_X = 3'd3,
    CFG_DIR_Y = 3'd4,
    CFG_DIR_Z = 3'd5
  } cfg_reg_e;

  // Product groups: three components of h, three of q, then the four dot products.
  typedef enum logic [3:0] {
    G_H0 = 4'd0,
    G_H1 = 4'd1,
    G_H2 = 4'd2,
    G_Q0 = 4'd3,
    G_Q1 = 4'd4,
    G_Q2 = 4'd5,
    G_A  = 4'd6,
    G_P  = 4'd7,
    G_QQ = 4'd8,
    G_T  = 4'd9
  } grp_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] v0_x;
    logic signed [COORD_W-1:0] v0_y;
    logic signed [COORD_W-1:0] v0_z;
    logic signed [COORD_W-1:0] v1_x;
    logic signed [COORD_W-1:0] v1_y;
    logic signed [COORD_W-1:0] v1_z;
    logic signed [COORD_W-1:0] v2_x;
    logic signed [COORD_W-1:0] v2_y;
    logic signed [COORD_W-1:0] v2_z;
    logic                      last_triangle;
  } in_item_t;

  typedef struct packed {
    logic              triangle_hit;
    logic [DIST_W-1:0] triangle_distance;
    logic              any_hit;
    logic [DIST_W-1:0] nearest_distance;
    logic              end_of_mesh;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic clear;
    logic sub;
  } mac_cmd_t;

endpackage

>>> design/rtnh_mac.sv
module rtnh_mac import rtnh_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mac_cmd_t                  cmd,
  input  logic signed [CROSS_W-1:0] op_a,
  input  logic signed [EDGE_W-1:0]  op_b,
  output logic                      busy,
  output logic signed [ACC_W-1:0]   acc
);

  localparam int CNT_W = $clog2(EDGE_W + 1);

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [ACC_W-1:0]        ma_r, ma_nxt;
  logic [EDGE_W-1:0]       mb_r, mb_nxt;
  logic                    neg_r, neg_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [CROSS_W-1:0]      mag_a;
  logic [EDGE_W-1:0]       mag_b;

  assign mag_a = op_a[CROSS_W-1] ? CROSS_W'(-op_a) : CROSS_W'(op_a);
  assign mag_b = op_b[EDGE_W-1] ? EDGE_W'(-op_b) : EDGE_W'(op_b);
  assign busy  = (cnt_r != '0);
  assign acc   = acc_r;

  // One multiplier bit per cycle; the shifted multiplicand is added or
  // subtracted straight into the accumulator.
  always_comb begin
    cnt_nxt = cnt_r;
    ma_nxt  = ma_r;
    mb_nxt  = mb_r;
    neg_nxt = neg_r;
    acc_nxt = acc_r;
    if (cmd.start) begin
      ma_nxt  = ACC_W'(mag_a);
      mb_nxt  = mag_b;
      neg_nxt = op_a[CROSS_W-1] ^ op_b[EDGE_W-1] ^ cmd.sub;
      cnt_nxt = CNT_W'(EDGE_W);
      if (cmd.clear) begin
        acc_nxt = '0;
      end
    end else if (busy) begin
      if (mb_r[0]) begin
        acc_nxt = neg_r ? $signed(acc_r - ma_r) : $signed(acc_r + ma_r);
      end
      ma_nxt  = ma_r << 1;
      mb_nxt  = mb_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    neg_r <= neg_nxt;
    acc_r <= acc_nxt;
  end

endmodule

>>> design/rtnh_div.sv
module rtnh_div import rtnh_pkg::*; #(
  parameter int STEPS = ACC_W + FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ACC_W-1:0]  num,
  input  logic [ACC_W-1:0]  den,
  output logic              busy,
  output logic [DIST_W-1:0] quo
);

  localparam int CNT_W = $clog2(STEPS + 1);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ACC_W-1:0]  num_r, num_nxt;
  logic [ACC_W-1:0]  rem_r, rem_nxt;
  logic [DIST_W-1:0] q_r, q_nxt;
  logic              sat_r, sat_nxt;
  logic [ACC_W:0]    sh;
  logic [ACC_W:0]    diff;
  logic              ge;

  assign busy = (cnt_r != '0);
  assign quo  = sat_r ? DIST_MAX : q_r;
  assign sh   = {rem_r, num_r[ACC_W-1]};
  assign diff = sh - {1'b0, den};
  assign ge   = (sh >= {1'b0, den});

  // Restoring division, one quotient bit per cycle. Once the quotient
  // passes the distance range it is pinned as saturated.
  always_comb begin
    cnt_nxt = cnt_r;
    num_nxt = num_r;
    rem_nxt = rem_r;
    q_nxt   = q_r;
    sat_nxt = sat_r;
    if (start) begin
      num_nxt = num;
      rem_nxt = '0;
      q_nxt   = '0;
      sat_nxt = 1'b0;
      cnt_nxt = CNT_W'(STEPS);
    end else if (busy) begin
      num_nxt = num_r << 1;
      rem_nxt = ge ? diff[ACC_W-1:0] : sh[ACC_W-1:0];
      q_nxt   = {q_r[DIST_W-2:0], ge};
      sat_nxt = sat_r | q_r[DIST_W-1];
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    sat_r <= sat_nxt;
  end

endmodule

>>> design/ray_triangle_nearest_hit_unit.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_item_t, one triangle per beat
// out_      output     out_valid/out_stall  out_item_t, one result per beat
// cfg_      input      cfg_wr_en            cfg_index, cfg_data (ray registers)
// One triangle at a time: the bit-serial multiply-accumulate unit forms all 24 products,
// and the bit-serial divider forms the distance. A missed triangle skips the divider.
// Reset is synchronous on rst_n and clears the ray registers and the running nearest hit.
// A finished result waits in the output register, and the next triangle is taken meanwhile.
module ray_triangle_nearest_hit_unit import rtnh_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  localparam logic [63:0] DET_EPS = (64'd1 << (2 * FRACTION_BITS)) / 64'd10000000;
  localparam logic signed [ACC_W-1:0] EPS = ACC_W'(DET_EPS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ISSUE = 7'b0000010,
    S_WAIT  = 7'b0000100,
    S_FIX   = 7'b0001000,
    S_CHK   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  grp_e   grp_r, grp_nxt;
  logic [1:0] term_r, term_nxt;

  logic signed [COORD_W-1:0] org_r [3];
  logic signed [COORD_W-1:0] dir_r [3];
  logic signed [EDGE_W-1:0]  e1_r [3];
  logic signed [EDGE_W-1:0]  e2_r [3];
  logic signed [EDGE_W-1:0]  s_r [3];
  logic signed [CROSS_W-1:0] h_r [3];
  logic signed [CROSS_W-1:0] qv_r [3];
  logic signed [ACC_W-1:0]   a_r, p_r, qq_r, t_r;
  logic                      last_r;
  logic                      hit_r;
  logic [DIST_W-1:0]         dist_r;

  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r;
  logic              seen_r, seen_nxt;
  logic [DIST_W-1:0] nearest_r, nearest_nxt;
  logic              seen_new;
  logic [DIST_W-1:0] nearest_new;

  mac_cmd_t                  mac_cmd;
  logic signed [CROSS_W-1:0] op_a;
  logic signed [EDGE_W-1:0]  op_b;
  logic                      mac_busy;
  logic signed [ACC_W-1:0]   acc;
  logic                      div_start;
  logic                      div_busy;
  logic [DIST_W-1:0]         div_quo;

  logic                      in_acc;
  logic                      is_cross;
  logic                      last_term;
  logic                      group_done;
  logic signed [ACC_W-1:0]   acc_sh;
  logic                      fits;
  logic signed [CROSS_W-1:0] cross_val;
  logic                      ok;
  logic                      out_load;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_cross   = (grp_r == G_H0) || (grp_r == G_H1) || (grp_r == G_H2) ||
                      (grp_r == G_Q0) || (grp_r == G_Q1) || (grp_r == G_Q2);
  assign last_term  = is_cross ? (term_r == 2'd1) : (term_r == 2'd2);
  assign group_done = (state_r == S_WAIT) && !mac_busy && last_term;

  assign mac_cmd.start = (state_r == S_ISSUE);
  assign mac_cmd.clear = (term_r == 2'd0);
  assign mac_cmd.sub   = is_cross && (term_r == 2'd1);

  // Cross components keep FRACTION_BITS fewer bits and saturate to 64 bits.
  assign acc_sh    = acc >>> FRACTION_BITS;
  assign fits      = (&acc_sh[ACC_W-1:CROSS_W-1]) || !(|acc_sh[ACC_W-1:CROSS_W-1]);
  assign cross_val = fits ? acc_sh[CROSS_W-1:0]
                   : (acc_sh[ACC_W-1] ? {1'b1, {(CROSS_W-1){1'b0}}}
                                      : {1'b0, {(CROSS_W-1){1'b1}}});

  assign ok = (a_r > EPS) && !p_r[ACC_W-1] && (p_r <= a_r) && !qq_r[ACC_W-1] &&
              ((p_r + qq_r) <= a_r) && !t_r[ACC_W-1] && (t_r != '0);
  assign div_start = (state_r == S_CHK) && ok;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (grp_r)
      G_H0: begin
        op_a = CROSS_W'(term_r[0] ? dir_r[2] : dir_r[1]);
        op_b = term_r[0] ? e2_r[1] : e2_r[2];
      end
      G_H1: begin
        op_a = CROSS_W'(term_r[0] ? dir_r[0] : dir_r[2]);
        op_b = term_r[0] ? e2_r[2] : e2_r[0];
      end
      G_H2: begin
        op_a = CROSS_W'(term_r[0] ? dir_r[1] : dir_r[0]);
        op_b = term_r[0] ? e2_r[0] : e2_r[1];
      end
      G_Q0: begin
        op_a = CROSS_W'(term_r[0] ? s_r[2] : s_r[1]);
        op_b = term_r[0] ? e1_r[1] : e1_r[2];
      end
      G_Q1: begin
        op_a = CROSS_W'(term_r[0] ? s_r[0] : s_r[2]);
        op_b = term_r[0] ? e1_r[2] : e1_r[0];
      end
      G_Q2: begin
        op_a = CROSS_W'(term_r[0] ? s_r[1] : s_r[0]);
        op_b = term_r[0] ? e1_r[0] : e1_r[1];
      end
      G_A: begin
        case (term_r)
          2'd0:    begin op_a = h_r[0]; op_b = e1_r[0]; end
          2'd1:    begin op_a = h_r[1]; op_b = e1_r[1]; end
          default: begin op_a = h_r[2]; op_b = e1_r[2]; end
        endcase
      end
      G_P: begin
        case (term_r)
          2'd0:    begin op_a = h_r[0]; op_b = s_r[0]; end
          2'd1:    begin op_a = h_r[1]; op_b = s_r[1]; end
          default: begin op_a = h_r[2]; op_b = s_r[2]; end
        endcase
      end
      G_QQ: begin
        case (term_r)
          2'd0:    begin op_a = qv_r[0]; op_b = EDGE_W'(dir_r[0]); end
          2'd1:    begin op_a = qv_r[1]; op_b = EDGE_W'(dir_r[1]); end
          default: begin op_a = qv_r[2]; op_b = EDGE_W'(dir_r[2]); end
        endcase
      end
      G_T: begin
        case (term_r)
          2'd0:    begin op_a = qv_r[0]; op_b = e2_r[0]; end
          2'd1:    begin op_a = qv_r[1]; op_b = e2_r[1]; end
          default: begin op_a = qv_r[2]; op_b = e2_r[2]; end
        endcase
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    grp_nxt   = grp_r;
    term_nxt  = term_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          grp_nxt   = G_H0;
          term_nxt  = 2'd0;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: state_nxt = S_WAIT;
      S_WAIT: begin
        if (!mac_busy) begin
          if (!last_term) begin
            term_nxt  = term_r + 2'd1;
            state_nxt = S_ISSUE;
          end else if (grp_r == G_T) begin
            state_nxt = S_FIX;
          end else begin
            term_nxt  = 2'd0;
            grp_nxt   = grp_e'(grp_r + 4'd1);
            state_nxt = S_ISSUE;
          end
        end
      end
      S_FIX: state_nxt = S_CHK;
      S_CHK: state_nxt = ok ? S_DIV : S_OUT;
      S_DIV: begin
        if (!div_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Running nearest hit including the triangle that is being reported.
  always_comb begin
    seen_new      = seen_r | hit_r;
    nearest_new   = (hit_r && (dist_r < nearest_r)) ? dist_r : nearest_r;
    seen_nxt      = seen_r;
    nearest_nxt   = nearest_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      seen_nxt      = last_r ? 1'b0 : seen_new;
      nearest_nxt   = last_r ? DIST_MAX : nearest_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      grp_r       <= G_H0;
      term_r      <= 2'd0;
      out_valid_r <= 1'b0;
      seen_r      <= 1'b0;
      nearest_r   <= DIST_MAX;
      for (int i = 0; i < 3; i++) begin
        org_r[i] <= '0;
        dir_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      grp_r       <= grp_nxt;
      term_r      <= term_nxt;
      out_valid_r <= out_valid_nxt;
      seen_r      <= seen_nxt;
      nearest_r   <= nearest_nxt;
      if (cfg_wr_en) begin
        case (cfg_reg_e'(cfg_index))
          CFG_ORG_X: org_r[0] <= cfg_data;
          CFG_ORG_Y: org_r[1] <= cfg_data;
          CFG_ORG_Z: org_r[2] <= cfg_data;
          CFG_DIR_X: dir_r[0] <= cfg_data;
          CFG_DIR_Y: dir_r[1] <= cfg_data;
          CFG_DIR_Z: dir_r[2] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      e1_r[0] <= EDGE_W'(in_data.v1_x) - EDGE_W'(in_data.v0_x);
      e1_r[1] <= EDGE_W'(in_data.v1_y) - EDGE_W'(in_data.v0_y);
      e1_r[2] <= EDGE_W'(in_data.v1_z) - EDGE_W'(in_data.v0_z);
      e2_r[0] <= EDGE_W'(in_data.v2_x) - EDGE_W'(in_data.v0_x);
      e2_r[1] <= EDGE_W'(in_data.v2_y) - EDGE_W'(in_data.v0_y);
      e2_r[2] <= EDGE_W'(in_data.v2_z) - EDGE_W'(in_data.v0_z);
      s_r[0]  <= EDGE_W'(org_r[0]) - EDGE_W'(in_data.v0_x);
      s_r[1]  <= EDGE_W'(org_r[1]) - EDGE_W'(in_data.v0_y);
      s_r[2]  <= EDGE_W'(org_r[2]) - EDGE_W'(in_data.v0_z);
      last_r  <= in_data.last_triangle;
    end
    if (group_done) begin
      case (grp_r)
        G_H0: h_r[0]  <= cross_val;
        G_H1: h_r[1]  <= cross_val;
        G_H2: h_r[2]  <= cross_val;
        G_Q0: qv_r[0] <= cross_val;
        G_Q1: qv_r[1] <= cross_val;
        G_Q2: qv_r[2] <= cross_val;
        G_A:  a_r     <= acc;
        G_P:  p_r     <= acc;
        G_QQ: qq_r    <= acc;
        G_T:  t_r     <= acc;
        default: ;
      endcase
    end
    // A back-facing determinant flips the sign of every dot product.
    if ((state_r == S_FIX) && a_r[ACC_W-1]) begin
      a_r  <= -a_r;
      p_r  <= -p_r;
      qq_r <= -qq_r;
      t_r  <= -t_r;
    end
    if ((state_r == S_CHK) && !ok) begin
      hit_r  <= 1'b0;
      dist_r <= '0;
    end
    if ((state_r == S_DIV) && !div_busy) begin
      hit_r  <= (div_quo != '0);
      dist_r <= div_quo;
    end
    if (out_load) begin
      out_data_r.triangle_hit      <= hit_r;
      out_data_r.triangle_distance <= dist_r;
      out_data_r.any_hit           <= seen_new;
      out_data_r.nearest_distance  <= nearest_new;
      out_data_r.end_of_mesh       <= last_r;
    end
  end

  rtnh_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mac_cmd),
    .op_a  (op_a),
    .op_b  (op_b),
    .busy  (mac_busy),
    .acc   (acc)
  );

  rtnh_div #(
    .STEPS (ACC_W + FRACTION_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (t_r),
    .den   (a_r),
    .busy  (div_busy),
    .quo   (div_quo)
  );

`ifndef NO_ASSERTIONS
  a_mac_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    mac_cmd.start |-> !mac_busy)
    else $error("product started while the multiplier was busy");

  a_hit_vs_distance: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.triangle_hit == (out_data_r.triangle_distance != '0)))
    else $error("hit flag disagrees with distance");

  a_nearest_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.triangle_hit) |->
      (out_data_r.any_hit &&
       (out_data_r.nearest_distance <= out_data_r.triangle_distance)))
    else $error("running nearest exceeds this hit");

  a_no_hit_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.any_hit) |-> (out_data_r.nearest_distance == DIST_MAX))
    else $error("nearest distance set without any hit");
`endif

endmodule
